[hdl/fpwf_pkg.sv]
`default_nettype none

package fpwf_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam logic [47:0] LayoutReset = 48'h1008_0808_0008;
    localparam logic [7:0] KindRgb = 8'd1;
    localparam logic [7:0] Bpp24 = 8'd24;
    localparam logic [7:0] Bpp32 = 8'd32;

    typedef enum logic [CfgIdxW-1:0] {
        REG_FB_BASE      = 3'd0,
        REG_LINE_PITCH   = 3'd1,
        REG_SCREEN_WIDTH = 3'd2,
        REG_SCREEN_HEIGHT = 3'd3,
        REG_BITS_PER_PIXEL = 3'd4,
        REG_FB_KIND      = 3'd5,
        REG_COLOR_LAYOUT = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_WRITTEN     = 2'd0,
        ST_OUT_OF_FB   = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] pos;
        logic [7:0] size;
    } t_comp;

    typedef struct packed {
        t_comp red;
        t_comp green;
        t_comp blue;
    } t_layout;

endpackage

`default_nettype wire

[hdl/fpwf_pack.sv]
`default_nettype none

module fpwf_pack
    import fpwf_pkg::*;
(
    input  wire logic [31:0] i_argb,
    input  wire t_layout     i_layout,
    output logic      [31:0] o_pixel_word
);

    // exact floor(p / 255) for p below 65280
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        begin
            t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
            div255 = t[15:8];
        end
    endfunction

    function automatic logic [7:0] scale(input logic [7:0] v, input logic [7:0] size);
        logic [15:0] p5;
        logic [15:0] p6;
        logic [3:0]  sh;
        begin
            p5 = {8'd0, v} * 16'd31;
            p6 = {8'd0, v} * 16'd63;
            sh = 4'd8 - {1'b0, size[2:0]};
            if (size == 8'd5) begin
                scale = div255(p5);
            end else if (size == 8'd6) begin
                scale = div255(p6);
            end else if (size >= 8'd8) begin
                scale = v;
            end else begin
                scale = v >> sh;
            end
        end
    endfunction

    function automatic logic [31:0] place(input logic [7:0] v, input t_comp c);
        logic [31:0] s;
        begin
            s = {24'd0, scale(v, c.size)};
            if (c.pos >= 8'd32) begin
                place = 32'd0;
            end else begin
                place = s << c.pos[4:0];
            end
        end
    endfunction

    assign o_pixel_word = place(i_argb[23:16], i_layout.red)
                        | place(i_argb[15:8], i_layout.green)
                        | place(i_argb[7:0], i_layout.blue);

endmodule

`default_nettype wire

[hdl/framebuffer_pixel_write_formatter.sv]
// a word accepted at a clock edge passes through the stage 1, stage 2 and output registers,
// and shows on the result ports marked by o_result_valid for exactly one cycle
// throughput: one word per cycle; busy stays low, start is never refused
// the receiver cannot stall: results are not held
// reset (i_rst_n low, synchronous) clears the pipeline valids and sets the configuration
// registers to their reset values; the pipeline data registers are not reset
`default_nettype none

module framebuffer_pixel_write_formatter
    import fpwf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic       [31:0] i_argb_color,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic       [63:0] i_cfg_data,
    output logic                   o_result_valid,
    output logic            [63:0] o_byte_address,
    output logic            [31:0] o_pixel_word,
    output logic             [2:0] o_store_bytes,
    output logic             [1:0] o_status
);

    logic [63:0] r_fb_base;
    logic [17:0] r_line_pitch;
    logic [15:0] r_screen_width;
    logic [15:0] r_screen_height;
    logic [7:0]  r_bpp;
    logic [7:0]  r_fb_kind;
    t_layout     r_layout;

    logic        r_v1;
    logic [15:0] r_x1;
    logic [15:0] r_y1;
    logic [31:0] r_argb1;

    logic        r_v2;
    t_status     r_status2;
    logic [31:0] r_off2;
    logic [31:0] r_word2;
    logic [2:0]  r_bytes2;

    logic        n_accept;
    logic        n_in_bounds;
    logic        n_fmt_ok;
    logic        n_is32;
    t_status     n_status;
    logic [32:0] n_row_off;
    logic [16:0] n_col_off;
    logic [31:0] n_off;
    logic [31:0] n_word;
    logic [2:0]  n_bytes;

    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign n_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_base <= '0;
            r_line_pitch <= '0;
            r_screen_width <= '0;
            r_screen_height <= '0;
            r_bpp <= '0;
            r_fb_kind <= '0;
            r_layout <= LayoutReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FB_BASE:        r_fb_base <= i_cfg_data;
                REG_LINE_PITCH:     r_line_pitch <= i_cfg_data[17:0];
                REG_SCREEN_WIDTH:   r_screen_width <= i_cfg_data[15:0];
                REG_SCREEN_HEIGHT:  r_screen_height <= i_cfg_data[15:0];
                REG_BITS_PER_PIXEL: r_bpp <= i_cfg_data[7:0];
                REG_FB_KIND:        r_fb_kind <= i_cfg_data[7:0];
                REG_COLOR_LAYOUT:   r_layout <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // stage 1: input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= n_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_x1 <= i_pos_x;
            r_y1 <= i_pos_y;
            r_argb1 <= i_argb_color;
        end
    end

    // stage 2: checks, offset products, packing
    fpwf_pack u_pack (
        .i_argb       (r_argb1),
        .i_layout     (r_layout),
        .o_pixel_word (n_word)
    );

    always_comb begin
        n_in_bounds = (r_fb_base != 64'd0) && !r_x1[15] && !r_y1[15]
                    && (r_x1 < r_screen_width) && (r_y1 < r_screen_height);
        n_fmt_ok = (r_fb_kind == KindRgb) && ((r_bpp == Bpp24) || (r_bpp == Bpp32));
        n_is32 = (r_bpp == Bpp32);
        n_row_off = {18'd0, r_y1[14:0]} * {15'd0, r_line_pitch};
        n_col_off = n_is32 ? {r_x1[14:0], 2'b00} : ({2'b00, r_x1[14:0]} + {1'b0, r_x1[14:0], 1'b0});
        n_off = n_row_off[31:0] + {15'd0, n_col_off};
        n_bytes = n_is32 ? 3'd4 : 3'd3;
        if (!n_in_bounds) begin
            n_status = ST_OUT_OF_FB;
        end else if (!n_fmt_ok) begin
            n_status = ST_UNSUPPORTED;
        end else begin
            n_status = ST_WRITTEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_status2 <= n_status;
            r_off2 <= n_off;
            r_word2 <= n_word;
            r_bytes2 <= n_bytes;
        end
    end

    // stage 3: base add and zeroing of rejected words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            o_status <= r_status2;
            if (r_status2 == ST_WRITTEN) begin
                o_byte_address <= r_fb_base + {32'd0, r_off2};
                o_pixel_word <= r_word2;
                o_store_bytes <= r_bytes2;
            end else begin
                o_byte_address <= '0;
                o_pixel_word <= '0;
                o_store_bytes <= '0;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/fpwf_chk.sv]
`default_nettype none

module fpwf_chk
    import fpwf_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_result_valid,
    input wire logic       [63:0] o_byte_address,
    input wire logic       [31:0] o_pixel_word,
    input wire logic        [2:0] o_store_bytes,
    input wire logic        [1:0] o_status
);

    a_word_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##2 o_result_valid)
        else $error("accepted word produced no result");

    a_result_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 3))
        else $error("result without accepted word");

    a_written_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_status == ST_WRITTEN) |->
            (o_store_bytes == 3'd3) || (o_store_bytes == 3'd4))
        else $error("written pixel with bad byte count");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_status != ST_WRITTEN) |->
            (o_byte_address == 64'd0) && (o_pixel_word == 32'd0) && (o_store_bytes == 3'd0))
        else $error("rejected pixel carries payload");

endmodule

bind framebuffer_pixel_write_formatter fpwf_chk u_fpwf_chk (.*);

`default_nettype wire

[verif/framebuffer_pixel_write_formatter_tb.sv]
`timescale 1ns / 1ps

module framebuffer_pixel_write_formatter_tb;
    import fpwf_pkg::*;

    localparam int RandomWords = 1900;
    localparam int SettleCycles = 6;
    localparam int QuietLimit = 500;
    localparam logic [47:0] Layout565 = 48'h0B05_0506_0005;
    localparam logic [47:0] Layout555 = 48'h0A05_0505_0005;
    localparam logic [47:0] LayoutBgr = 48'h0008_0808_1008;
    localparam logic [47:0] LayoutOddA = 48'h2808_1A07_1FC8;
    localparam logic [47:0] LayoutOddB = 48'h0000_0301_FF04;

    typedef struct packed {
        logic [63:0] addr;
        logic [31:0] word;
        logic [2:0]  nbytes;
        t_status     status;
    } t_store_rec;

    class pixel_write_checker;
        logic [63:0] base = '0;
        logic [17:0] pitch = '0;
        logic [15:0] width = '0;
        logic [15:0] height = '0;
        logic [7:0]  bpp = '0;
        logic [7:0]  kind = '0;
        logic [47:0] layout = LayoutReset;
        t_store_rec  expected_stores[$];
        int          errors = 0;

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
            case (t_cfg_reg'(idx))
                REG_FB_BASE:        base = val;
                REG_LINE_PITCH:     pitch = val[17:0];
                REG_SCREEN_WIDTH:   width = val[15:0];
                REG_SCREEN_HEIGHT:  height = val[15:0];
                REG_BITS_PER_PIXEL: bpp = val[7:0];
                REG_FB_KIND:        kind = val[7:0];
                REG_COLOR_LAYOUT:   layout = val[47:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] scale_chan(logic [7:0] v, logic [7:0] sz);
            logic [31:0] wide;
            wide = {24'd0, v};
            if (sz == 8'd5) return wide * 32'd31 / 32'd255;
            if (sz == 8'd6) return wide * 32'd63 / 32'd255;
            if (sz >= 8'd8) return wide;
            return wide >> (8 - sz);
        endfunction

        function logic [31:0] place_chan(logic [7:0] v, t_comp c);
            if (c.pos >= 8'd32) return 32'd0;
            return scale_chan(v, c.size) << c.pos;
        endfunction

        function t_store_rec predict_store(logic [15:0] x, logic [15:0] y, logic [31:0] argb);
            t_store_rec r;
            logic [31:0] off;
            t_layout lay;
            r = '0;
            r.status = ST_WRITTEN;
            lay = t_layout'(layout);
            if (base == 64'd0 || x[15] || y[15] || x >= width || y >= height) begin
                r.status = ST_OUT_OF_FB;
                return r;
            end
            if (kind != KindRgb || (bpp != Bpp24 && bpp != Bpp32)) begin
                r.status = ST_UNSUPPORTED;
                return r;
            end
            off = {16'd0, y} * {14'd0, pitch} + {16'd0, x} * {27'd0, bpp[7:3]};
            r.addr = base + {32'd0, off};
            r.word = place_chan(argb[23:16], lay.red) | place_chan(argb[15:8], lay.green)
                   | place_chan(argb[7:0], lay.blue);
            r.nbytes = (bpp == Bpp32) ? 3'd4 : 3'd3;
            return r;
        endfunction

        function void note_write(logic [15:0] x, logic [15:0] y, logic [31:0] argb);
            expected_stores.push_back(predict_store(x, y, argb));
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void check_store(logic [63:0] addr, logic [31:0] word, logic [2:0] nb,
                                  logic [1:0] st);
            t_store_rec want;
            if (expected_stores.size() == 0) begin
                flag($sformatf("unexpected word: addr %h pixel %h bytes %0d status %0d",
                               addr, word, nb, st));
                return;
            end
            want = expected_stores.pop_front();
            if (want.addr !== addr || want.word !== word || want.nbytes !== nb ||
                want.status !== st) begin
                flag($sformatf({"mismatch: expected addr %h pixel %h bytes %0d status %0d,",
                                " got addr %h pixel %h bytes %0d status %0d"},
                               want.addr, want.word, want.nbytes, want.status,
                               addr, word, nb, st));
            end
        endfunction

        function int pending();
            return expected_stores.size();
        endfunction

        function void flush_leftover();
            t_store_rec want;
            while (expected_stores.size() > 0) begin
                want = expected_stores.pop_front();
                flag($sformatf("missing word: expected addr %h pixel %h bytes %0d status %0d",
                               want.addr, want.word, want.nbytes, want.status));
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [15:0]        i_pos_x;
    logic [15:0]        i_pos_y;
    logic [31:0]        i_argb_color;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [63:0]        i_cfg_data;
    logic               o_result_valid;
    logic [63:0]        o_byte_address;
    logic [31:0]        o_pixel_word;
    logic [2:0]         o_store_bytes;
    logic [1:0]         o_status;

    pixel_write_checker chk = new();
    int quiet_cycles = 0;

    framebuffer_pixel_write_formatter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_argb_color   (i_argb_color),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_byte_address (o_byte_address),
        .o_pixel_word   (o_pixel_word),
        .o_store_bytes  (o_store_bytes),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : monitor
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_result_valid) begin
                chk.check_store(o_byte_address, o_pixel_word, o_store_bytes, o_status);
                moved = 1'b1;
            end
            if (start && !busy) begin
                chk.note_write(i_pos_x, i_pos_y, i_argb_color);
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                chk.set_reg(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
        end
        if (moved) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QuietLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_pixel(input logic [15:0] x, input logic [15:0] y,
                              input logic [31:0] argb);
        start <= 1'b1;
        i_pos_x <= x;
        i_pos_y <= y;
        i_argb_color <= argb;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            i_pos_x <= 16'($urandom);
            i_pos_y <= 16'($urandom);
            i_argb_color <= $urandom;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_fb(input logic [63:0] base, input logic [17:0] pitch,
                              input logic [15:0] w, input logic [15:0] h,
                              input logic [7:0] bpp, input logic [7:0] kind,
                              input logic [47:0] lay);
        write_reg(REG_FB_BASE, base);
        write_reg(REG_LINE_PITCH, {46'd0, pitch});
        write_reg(REG_SCREEN_WIDTH, {48'd0, w});
        write_reg(REG_SCREEN_HEIGHT, {48'd0, h});
        write_reg(REG_BITS_PER_PIXEL, {56'd0, bpp});
        write_reg(REG_FB_KIND, {56'd0, kind});
        write_reg(REG_COLOR_LAYOUT, {16'd0, lay});
    endtask

    function automatic logic [15:0] pick_extent();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r == 2) return 16'd1;
        if (r == 3) return 16'($urandom);
        return 16'($urandom_range(2000, 1));
    endfunction

    task automatic randomize_fb();
        logic [63:0] base;
        logic [17:0] pitch;
        logic [7:0]  bpp;
        logic [7:0]  kind;
        logic [47:0] lay;
        int r;
        r = $urandom_range(9);
        base = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom};
        r = $urandom_range(9);
        pitch = (r == 0) ? 18'd0 : (r == 1) ? '1 : 18'($urandom);
        r = $urandom_range(9);
        bpp = (r < 4) ? Bpp32 : (r < 8) ? Bpp24 : 8'($urandom);
        kind = ($urandom_range(9) == 0) ? 8'($urandom) : KindRgb;
        case ($urandom_range(6))
            0: lay = LayoutReset;
            1: lay = Layout565;
            2: lay = Layout555;
            3: lay = LayoutBgr;
            4: lay = {$urandom, 16'($urandom)};
            default: lay = {8'($urandom_range(40, 0)), 8'($urandom_range(10, 0)),
                            8'($urandom_range(40, 0)), 8'($urandom_range(10, 0)),
                            8'($urandom_range(40, 0)), 8'($urandom_range(10, 0))};
        endcase
        program_fb(base, pitch, pick_extent(), pick_extent(), bpp, kind, lay);
    endtask

    task automatic pick_pixel(output logic [15:0] x, output logic [15:0] y);
        int r;
        int xlim;
        int ylim;
        r = $urandom_range(9);
        xlim = (chk.width >= 16'h8000) ? 32768 : int'(chk.width);
        ylim = (chk.height >= 16'h8000) ? 32768 : int'(chk.height);
        if (r < 7 && xlim > 0 && ylim > 0) begin
            x = 16'($urandom_range(xlim - 1, 0));
            y = 16'($urandom_range(ylim - 1, 0));
        end else if (r == 7) begin
            x = 16'(chk.width - $urandom_range(1, 0));
            y = 16'(chk.height - $urandom_range(1, 0));
        end else begin
            x = 16'($urandom);
            y = 16'($urandom);
        end
    endtask

    initial begin
        int sent;
        int phase_len;
        int k;
        bit no_gaps;
        logic [15:0] px;
        logic [15:0] py;

        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_pos_x <= '0;
        i_pos_y <= '0;
        i_argb_color <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_FB_BASE;
        i_cfg_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no framebuffer after reset
        send_pixel(16'd0, 16'd0, 32'hFFFF_FFFF);
        send_pixel(16'd5, 16'd5, 32'h1234_5678);
        settle();

        program_fb(64'h0000_0000_8000_0000, 18'd2560, 16'd640, 16'd480, Bpp32, KindRgb,
                   LayoutReset);
        send_pixel(16'd0, 16'd0, 32'h00FF_FFFF);
        send_pixel(16'd639, 16'd479, 32'hFF00_0000);
        send_pixel(16'd640, 16'd0, 32'h0012_3456);
        send_pixel(16'd0, 16'd480, 32'h0012_3456);
        send_pixel(16'hFFFF, 16'd0, 32'h0012_3456);
        send_pixel(16'd0, 16'hFFFF, 32'h0012_3456);
        send_pixel(16'h8000, 16'h8000, 32'hFFFF_FFFF);
        send_pixel(16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
        settle();

        // top of address space, offset wraps
        program_fb('1, '1, 16'hFFFF, 16'hFFFF, Bpp24, KindRgb, Layout565);
        send_pixel(16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF);
        send_pixel(16'd1, 16'd1, 32'h0080_8080);
        send_pixel(16'd0, 16'd0, 32'h0000_0000);
        settle();

        // fields past bit 31, odd sizes
        program_fb(64'h0000_1234_0000_0000, 18'd4096, 16'd1024, 16'd768, Bpp32, KindRgb,
                   LayoutOddA);
        send_pixel(16'd100, 16'd200, 32'h80FF_7F01);
        send_pixel(16'd1023, 16'd767, 32'hFFFF_FFFF);
        settle();
        write_reg(REG_COLOR_LAYOUT, {16'd0, LayoutOddB});
        send_pixel(16'd3, 16'd4, 32'hFFFF_FFFF);
        settle();

        // unsupported formats, also combined with an out-of-range pixel and a zero base
        write_reg(REG_FB_KIND, 64'd0);
        send_pixel(16'd1, 16'd1, 32'h00AA_BBCC);
        settle();
        write_reg(REG_FB_KIND, 64'd2);
        send_pixel(16'd1, 16'd1, 32'h00AA_BBCC);
        settle();
        write_reg(REG_FB_KIND, {56'd0, KindRgb});
        write_reg(REG_BITS_PER_PIXEL, 64'd16);
        send_pixel(16'd2, 16'd2, 32'h00AA_BBCC);
        send_pixel(16'd1024, 16'd0, 32'h00AA_BBCC);
        settle();
        write_reg(REG_BITS_PER_PIXEL, 64'd0);
        send_pixel(16'd2, 16'd2, 32'h00AA_BBCC);
        settle();
        write_reg(REG_BITS_PER_PIXEL, {56'd0, Bpp24});
        write_reg(REG_FB_BASE, 64'd0);
        send_pixel(16'd2, 16'd2, 32'h00AA_BBCC);
        settle();

        sent = 0;
        while (sent < RandomWords) begin
            randomize_fb();
            phase_len = $urandom_range(200, 60);
            no_gaps = ($urandom_range(3) == 0);
            for (k = 0; k < phase_len; k++) begin
                pick_pixel(px, py);
                send_pixel(px, py, $urandom);
                if (!no_gaps) pause(pick_gap());
            end
            sent += phase_len;
            settle();
        end

        chk.flush_leftover();
        if (chk.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
